// ----- rtl/pcbrl_pkg.sv -----
// shared types and constants of the per-class burst rate limiter
`timescale 1ns / 1ps
`default_nettype none
package pcbrl_pkg;

  // field widths of one transfer
  localparam int OP_W     = 2;
  localparam int CLASS_W  = 5;
  localparam int TICK_W   = 32;
  localparam int WIN_W    = 16;
  localparam int CNT_W    = 8;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;

  // default table size
  localparam int NUM_CLASSES_DEF = 17;

  // operation codes carried in tuser; the unused code behaves as a check
  typedef enum logic [OP_W-1:0] {
    OP_CONFIG = 2'd0,
    OP_CHECK  = 2'd1,
    OP_TAKE   = 2'd2
  } op_t;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // one table entry
  typedef struct packed {
    logic [TICK_W-1:0] start;
    logic [CNT_W-1:0]  count;
    logic [WIN_W-1:0]  length;
    logic [CNT_W-1:0]  limit;
  } entry_t;

  // value of an entry that was never written
  localparam entry_t ENTRY_RESET = '{start: '0, count: '0, length: '0, limit: CNT_W'(1)};

  // controller to datapath
  typedef struct packed {
    logic accept;   // latch item, issue table read
    logic exec;     // evaluate, write back, load result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free; // output register can take a result this cycle
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/pcbrl_ram.sv -----
// generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
`default_nettype none
module pcbrl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 17,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pcbrl_ctrl.sv -----
// controller state machine: accept, then evaluate and write back
`timescale 1ns / 1ps
`default_nettype none
module pcbrl_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire pcbrl_pkg::dp_sts_t    sts,
  output      pcbrl_pkg::ctrl_cmd_t  cmd
);
  import pcbrl_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = 1'b0;
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      S_EXEC: begin
        cmd.exec = sts.out_free;
      end
      default: ;
    endcase
  end

  // checks
  a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == S_EXEC)
    else $error("accepted transfer did not move to evaluation");
  a_exec_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> sts.out_free)
    else $error("evaluation while result register is blocked");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept && cmd.exec))
    else $error("accept and evaluate in the same cycle");

endmodule
`default_nettype wire

// ----- rtl/pcbrl_dp.sv -----
// datapath: item latch, class table, decision logic, result register
`timescale 1ns / 1ps
`default_nettype none
module pcbrl_dp #(
  parameter int NUM_CLASSES = pcbrl_pkg::NUM_CLASSES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire pcbrl_pkg::ctrl_cmd_t                cmd,
  output      pcbrl_pkg::dp_sts_t                  sts,
  input  wire logic [pcbrl_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic [pcbrl_pkg::OP_W-1:0]          in_tuser,
  input  wire logic                                cfg_wr_en,
  input  wire logic                                cfg_wr_data,
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  output      logic [pcbrl_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import pcbrl_pkg::*;

  localparam int ADDR_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam logic [CLASS_W:0] CLS_LIMIT = (CLASS_W + 1)'(NUM_CLASSES);

  // incoming fields
  logic [CLASS_W-1:0] in_class;
  logic [ADDR_W-1:0]  in_addr;
  assign in_class = in_tdata[CLASS_W-1:0];
  assign in_addr  = in_class[ADDR_W-1:0];

  // latched item
  logic [OP_W-1:0]    op_r;
  logic [CLASS_W-1:0] class_r;
  logic [TICK_W-1:0]  now_r;
  logic [WIN_W-1:0]   win_r;
  logic [CNT_W-1:0]   lim_r;
  logic               hit_r;

  // configuration and table valid bits
  logic                   limiting_en_r;
  logic [NUM_CLASSES-1:0] valid_r;

  // result register
  logic out_valid_r, out_valid_nxt;
  logic allowed_r, invalid_r;

  // table port
  logic              ram_we;
  entry_t            ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  logic [ADDR_W-1:0] addr_r;

  // item latch on accept
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_tuser;
      class_r <= in_class;
      now_r   <= in_tdata[CLASS_W +: TICK_W];
      win_r   <= in_tdata[CLASS_W + TICK_W +: WIN_W];
      lim_r   <= in_tdata[CLASS_W + TICK_W + WIN_W +: CNT_W];
      addr_r  <= in_addr;
      hit_r   <= valid_r[in_addr];
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limiting_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      limiting_en_r <= cfg_wr_data;
    end
  end

  // class table
  pcbrl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_CLASSES),
    .ADDR_W(ADDR_W)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(addr_r),
    .wr_data(ram_wdata),
    .rd_en  (cmd.accept),
    .rd_addr(in_addr),
    .rd_data(ram_rdata)
  );

  // decision and update
  entry_t            ent;
  logic              cls_ok;
  logic [TICK_W:0]   win_end;
  logic              dec_allowed;
  logic              dec_write;
  entry_t            dec_entry;
  logic              is_take;

  always_comb begin
    ent         = hit_r ? entry_t'(ram_rdata) : ENTRY_RESET;
    cls_ok      = {1'b0, class_r} < CLS_LIMIT;
    is_take     = op_r == OP_TAKE;
    win_end     = {1'b0, ent.start} + (TICK_W + 1)'(ent.length);
    dec_allowed = 1'b1;
    dec_write   = 1'b0;
    dec_entry   = ent;
    if (!cls_ok) begin
      dec_allowed = 1'b0;
    end else if (op_r == OP_CONFIG) begin
      dec_write        = 1'b1;
      dec_entry.start  = '0;
      dec_entry.count  = '0;
      dec_entry.length = win_r;
      dec_entry.limit  = lim_r;
    end else if (limiting_en_r && (ent.length != '0)) begin
      if (ent.start > now_r) begin
        // tick wrapped: restart the window empty
        dec_write       = is_take;
        dec_entry.start = now_r;
        dec_entry.count = '0;
      end else if (win_end > {1'b0, now_r}) begin
        // inside the window
        if (ent.count >= ent.limit) begin
          dec_allowed = 1'b0;
        end else if (ent.count != '1) begin
          dec_write       = is_take;
          dec_entry.count = ent.count + CNT_W'(1);
        end
      end else begin
        // window expired: open a new one holding this packet
        dec_write       = is_take;
        dec_entry.start = now_r;
        dec_entry.count = CNT_W'(1);
      end
    end
  end

  assign ram_we    = cmd.exec && dec_write;
  assign ram_wdata = dec_entry;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[addr_r] <= 1'b1;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      allowed_r <= dec_allowed;
      invalid_r <= !cls_ok;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {{(OUT_DATA_W - 2){1'b0}}, invalid_r, allowed_r};

  // checks
  a_exec_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("evaluation did not load the result register");
  a_invalid_denied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(allowed_r && invalid_r))
    else $error("invalid class reported as allowed");
  a_write_valid_class: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> cls_ok)
    else $error("table write for a class outside the table");

endmodule
`default_nettype wire

// ----- rtl/per_class_burst_rate_limiter_unit.sv -----
// top level of the per-class burst rate limiter
//
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready  | tuser op, tdata class/tick/window/limit
//  out_    | master    | out_tvalid / out_tready| tdata allowed, class_invalid
//  cfg_    | write     | cfg_wr_en              | cfg_wr_data limiting_enabled
//
//  Each item passes through two steps: the registered table read, then evaluation and
//  write-back of the entry; a new item is accepted only after the last one is evaluated.
//  Reset is synchronous, active low; per-entry valid bits make the table read as its
//  reset contents at once, so there is no clearing pass.
//  A result waits in the output register while the next item is accepted and read;
//  evaluation stalls only while that register still holds an untaken result.
`timescale 1ns / 1ps
`default_nettype none
module per_class_burst_rate_limiter_unit #(
  parameter int NUM_CLASSES = pcbrl_pkg::NUM_CLASSES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  // [4:0] packet_class, [36:5] now_tick, [52:37] window_ticks, [60:53] burst_limit, rest 0
  input  wire logic [pcbrl_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] op
  input  wire logic [pcbrl_pkg::OP_W-1:0]       in_tuser,
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  // [0] allowed, [1] class_invalid, rest 0
  output      logic [pcbrl_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                             cfg_wr_en,
  input  wire logic                             cfg_wr_data
);
  import pcbrl_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // controller
  pcbrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  pcbrl_dp #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ----- tb/pcbrl_verdict_checker.sv -----
// checker that predicts and compares rate limiter verdicts on the stream channels
`timescale 1ns / 1ps
module pcbrl_verdict_checker #(
  parameter int NUM_CLASSES = pcbrl_pkg::NUM_CLASSES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [pcbrl_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [pcbrl_pkg::OP_W-1:0]       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [pcbrl_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,
  output int                               fail_count,
  output int                               pending
);
  import pcbrl_pkg::*;

  typedef struct packed {
    logic allowed;
    logic class_invalid;
  } verdict_t;

  // shadow copy of the class table and the enable register
  logic [TICK_W-1:0] shadow_start [NUM_CLASSES];
  logic [CNT_W-1:0]  shadow_count [NUM_CLASSES];
  logic [WIN_W-1:0]  shadow_length [NUM_CLASSES];
  logic [CNT_W-1:0]  shadow_limit [NUM_CLASSES];
  logic              shadow_enabled;

  verdict_t pending_verdicts [$];
  verdict_t oldest_verdict;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(string what);
    $display("%0t: verdict mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // decide one request and apply its effect on the shadow table
  function automatic verdict_t predict_verdict(logic [OP_W-1:0] op, logic [CLASS_W-1:0] cls,
                                               logic [TICK_W-1:0] now, logic [WIN_W-1:0] win,
                                               logic [CNT_W-1:0] lim);
    verdict_t v;
    logic take;
    logic [TICK_W:0] win_end;
    v.allowed = 1'b1;
    v.class_invalid = 1'b0;
    take = (op == OP_TAKE);
    if (cls >= NUM_CLASSES) begin
      v.allowed = 1'b0;
      v.class_invalid = 1'b1;
    end else if (op == OP_CONFIG) begin
      shadow_length[cls] = win;
      shadow_limit[cls] = lim;
      shadow_start[cls] = '0;
      shadow_count[cls] = '0;
    end else if (shadow_enabled && shadow_length[cls] != '0) begin
      // window end carries one extra bit so it never wraps
      win_end = {1'b0, shadow_start[cls]} + (TICK_W+1)'(shadow_length[cls]);
      if (shadow_start[cls] > now) begin
        // tick wrapped behind the window start
        if (take) begin
          shadow_start[cls] = now;
          shadow_count[cls] = '0;
        end
      end else if (win_end > {1'b0, now}) begin
        if (shadow_count[cls] >= shadow_limit[cls]) begin
          v.allowed = 1'b0;
        end else if (take && shadow_count[cls] != {CNT_W{1'b1}}) begin
          shadow_count[cls] = shadow_count[cls] + 1'b1;
        end
      end else if (take) begin
        shadow_start[cls] = now;
        shadow_count[cls] = CNT_W'(1);
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        shadow_start[i] = '0;
        shadow_count[i] = '0;
        shadow_length[i] = '0;
        shadow_limit[i] = CNT_W'(1);
      end
      shadow_enabled = 1'b1;
      pending_verdicts.delete();
    end else begin
      if (cfg_wr_en) begin
        shadow_enabled = cfg_wr_data;
      end
      // result transfer against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("result 0x%0h with no verdict waiting", out_tdata));
        end else begin
          oldest_verdict = pending_verdicts.pop_front();
          if (out_tdata[0] !== oldest_verdict.allowed) begin
            report_mismatch($sformatf("allowed expected %0b got %0b",
                                      oldest_verdict.allowed, out_tdata[0]));
          end
          if (out_tdata[1] !== oldest_verdict.class_invalid) begin
            report_mismatch($sformatf("class_invalid expected %0b got %0b",
                                      oldest_verdict.class_invalid, out_tdata[1]));
          end
        end
      end
      // request transfer: predict its verdict
      if (in_tvalid && in_tready) begin
        pending_verdicts.push_back(predict_verdict(in_tuser, in_tdata[4:0], in_tdata[36:5],
                                                   in_tdata[52:37], in_tdata[60:53]));
      end
    end
    pending <= pending_verdicts.size();
  end

endmodule

// ----- tb/tb_per_class_burst_rate_limiter_unit.sv -----
// testbench top: stimulus, flow control and verdict for the per-class rate limiter
`timescale 1ns / 1ps
module tb_per_class_burst_rate_limiter_unit;
  import pcbrl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC,
    RX_BURSTY
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [4:0] class, [36:5] tick, [52:37] window, [60:53] limit
  logic [OP_W-1:0]       in_tuser = '0;   // [1:0] op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [0] allowed, [1] class_invalid
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_wr_data = 1'b0;

  int       fail_count;
  int       pending;
  int       cycle_count = 0;
  int       sent_count = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b1;
  rx_mode_t rx_mode = RX_COIN;
  int       rx_phase = 0;
  int       rx_hold = 0;

  per_class_burst_rate_limiter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  pcbrl_verdict_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    case (rx_mode)
      RX_ALWAYS: begin
        out_tready <= 1'b1;
      end
      RX_COIN: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      RX_PERIODIC: begin
        out_tready <= (rx_phase % 5) < 3;
        rx_phase <= rx_phase + 1;
      end
      default: begin
        if (rx_hold != 0) begin
          out_tready <= 1'b0;
          rx_hold <= rx_hold - 1;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 15) == 0) rx_hold <= $urandom_range(3, 12);
        end
      end
    endcase
  end

  // one request transfer, with bursts and gaps on the sender side
  task automatic send_request(logic [OP_W-1:0] op, logic [CLASS_W-1:0] cls,
                              logic [TICK_W-1:0] tick, logic [WIN_W-1:0] win,
                              logic [CNT_W-1:0] lim);
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, lim, win, tick, cls};
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    sent_count++;
  endtask

  // stop sending and wait for every verdict to come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_limiting(logic en);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly configure-then-traffic sequences on one class, some noise
  task automatic run_random_phase(int n_items);
    int stop_at;
    int steps;
    int r;
    logic [CLASS_W-1:0] cls;
    logic [WIN_W-1:0]   win;
    logic [CNT_W-1:0]   lim;
    logic [TICK_W-1:0]  tick;
    logic [OP_W-1:0]    op;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        cls = ($urandom_range(0, 9) == 0) ? CLASS_W'($urandom_range(NUM_CLASSES_DEF, 31))
                                          : CLASS_W'($urandom_range(0, NUM_CLASSES_DEF - 1));
        r = $urandom_range(0, 9);
        if (r == 0) win = '0;
        else if (r == 1) win = '1;
        else if (r == 2) win = WIN_W'($urandom_range(0, 65535));
        else win = WIN_W'($urandom_range(1, 40));
        r = $urandom_range(0, 9);
        if (r == 0) lim = '0;
        else if (r == 1) lim = '1;
        else if (r == 2) lim = CNT_W'($urandom_range(0, 255));
        else lim = CNT_W'($urandom_range(1, 5));
        r = $urandom_range(0, 9);
        if (r == 0) tick = $urandom;
        else if (r == 1) tick = 32'hFFFF_FFFF - $urandom_range(0, 50);
        else tick = $urandom_range(0, 100);
        send_request(OP_CONFIG, cls, $urandom, win, lim);
        steps = $urandom_range(4, 16);
        repeat (steps) begin
          r = $urandom_range(0, 19);
          if (r == 0) op = OP_UNUSED;
          else if (r < 5) op = OP_CHECK;
          else op = OP_TAKE;
          r = $urandom_range(0, 19);
          if (r == 0) tick = tick - $urandom_range(1, 200);
          else if (r == 1) tick = tick + $urandom_range(0, 65535);
          else tick = tick + $urandom_range(0, win / 4 + 1);
          send_request(op, cls, tick, WIN_W'($urandom), CNT_W'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_request(OP_W'($urandom_range(0, 3)), CLASS_W'($urandom_range(0, 31)),
                       $urandom, WIN_W'($urandom_range(0, 65535)),
                       CNT_W'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // untouched table, invalid classes and the unused op
    send_request(OP_CHECK, 5'd0, '0, '0, '0);
    send_request(OP_TAKE, 5'd16, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send_request(OP_CONFIG, 5'd17, 32'd1, 16'd5, 8'd5);
    send_request(OP_CHECK, 5'd31, 32'd2, '0, '0);
    send_request(OP_TAKE, 5'd20, 32'd3, '0, '0);
    send_request(OP_UNUSED, 5'd24, 32'd4, '0, '0);

    // window of 100, two per window: open, fill, deny, boundary, wrapped tick
    send_request(OP_CONFIG, 5'd16, '0, 16'd100, 8'd2);
    send_request(OP_TAKE, 5'd16, 32'd1000, '0, '0);
    send_request(OP_TAKE, 5'd16, 32'd1050, '0, '0);
    send_request(OP_TAKE, 5'd16, 32'd1060, '0, '0);
    send_request(OP_CHECK, 5'd16, 32'd1070, '0, '0);
    send_request(OP_TAKE, 5'd16, 32'd1100, '0, '0);
    send_request(OP_TAKE, 5'd16, 32'd500, '0, '0);
    send_request(OP_CHECK, 5'd16, 32'd501, '0, '0);

    // largest window: end past the 32-bit range
    send_request(OP_CONFIG, 5'd0, '0, 16'hFFFF, 8'hFF);
    send_request(OP_TAKE, 5'd0, 32'hFFFF_FFFF, '0, '0);
    send_request(OP_TAKE, 5'd0, 32'hFFFF_FFFF, '0, '0);
    send_request(OP_CHECK, 5'd0, '0, '0, '0);

    // zero limit: denied inside, a new window still counts one
    send_request(OP_CONFIG, 5'd1, '0, 16'd10, 8'd0);
    send_request(OP_TAKE, 5'd1, 32'd5, '0, '0);
    send_request(OP_TAKE, 5'd1, 32'd20, '0, '0);
    send_request(OP_TAKE, 5'd1, 32'd21, '0, '0);
    send_request(OP_UNUSED, 5'd1, 32'd22, '0, '0);

    // limiting off: valid classes pass, invalid ones still denied
    set_limiting(1'b0);
    send_request(OP_TAKE, 5'd1, 32'd23, '0, '0);
    send_request(OP_CONFIG, 5'd2, 32'd24, 16'd1, 8'd1);
    send_request(OP_CHECK, 5'd30, 32'd25, '0, '0);
    set_limiting(1'b1);

    // fill a 255 limit up to the top of the count
    send_request(OP_CONFIG, 5'd3, $urandom, 16'hFFFF, 8'hFF);
    for (int i = 0; i < 260; i++) begin
      send_request(OP_TAKE, 5'd3, 32'd100 + i, WIN_W'($urandom), CNT_W'($urandom));
    end

    for (int p = 0; p < 5; p++) begin
      set_limiting((p % 3) != 2);
      gaps_on = (p != 1);
      rx_mode <= rx_mode_t'(p % 4);
      run_random_phase(180);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pcbrl_pkg.sv
rtl/pcbrl_ram.sv
rtl/pcbrl_ctrl.sv
rtl/pcbrl_dp.sv
rtl/per_class_burst_rate_limiter_unit.sv
tb/pcbrl_verdict_checker.sv
tb/tb_per_class_burst_rate_limiter_unit.sv
